>>> hw/rtl/bbhs_pkg.sv
// shared types and constants for the bicubic patch halving block
package bbhs_pkg;

    localparam int unsigned PATCH_DIM = 4;
    localparam int unsigned ROW_BITS  = 2;

    localparam logic [ROW_BITS-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_BITS-1:0] LAST_ROW  = 2'd3;

    // split direction codes
    localparam logic DIR_ROWS = 1'b0;
    localparam logic DIR_COLS = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                store_en;
        logic [ROW_BITS-1:0] store_row;
        logic                load_dir;
        logic                step1;
        logic                step2;
        logic                step3;
        logic [ROW_BITS-1:0] emit_row;
    } bbhs_cmd_t;

endpackage

>>> hw/rtl/bbhs_datapath.sv
// patch store and de casteljau halving datapath, four lanes in parallel
module bbhs_datapath #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bbhs_pkg::bbhs_cmd_t                    cmd,
    input  logic [VALUE_WIDTH-1:0]                 coef [bbhs_pkg::PATCH_DIM],
    input  logic                                   mode,
    output logic [VALUE_WIDTH-1:0]                 left [bbhs_pkg::PATCH_DIM],
    output logic [VALUE_WIDTH-1:0]                 right [bbhs_pkg::PATCH_DIM]
);
    import bbhs_pkg::*;

    localparam int unsigned W = VALUE_WIDTH;

    // floor((a + b) / 2) on a sum one bit wider than the operands
    function automatic logic [W-1:0] half_sum(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    logic [W-1:0] store_reg [PATCH_DIM][PATCH_DIM];
    logic         dir_reg;

    // lane k, element j: one row or one column of the patch
    logic [W-1:0] lane [PATCH_DIM][PATCH_DIM];

    logic [W-1:0] l1_reg  [PATCH_DIM];
    logic [W-1:0] mid_reg [PATCH_DIM];
    logic [W-1:0] r2_reg  [PATCH_DIM];
    logic [W-1:0] l2_reg  [PATCH_DIM];
    logic [W-1:0] r1_reg  [PATCH_DIM];
    logic [W-1:0] c_reg   [PATCH_DIM];

    logic [W-1:0] l1_next  [PATCH_DIM];
    logic [W-1:0] mid_next [PATCH_DIM];
    logic [W-1:0] r2_next  [PATCH_DIM];
    logic [W-1:0] l2_next  [PATCH_DIM];
    logic [W-1:0] r1_next  [PATCH_DIM];
    logic [W-1:0] c_next   [PATCH_DIM];

    logic [W-1:0] lft [PATCH_DIM][PATCH_DIM];
    logic [W-1:0] rgt [PATCH_DIM][PATCH_DIM];

    always_comb
    begin
        for (int k = 0; k < PATCH_DIM; k++)
        begin
            for (int j = 0; j < PATCH_DIM; j++)
            begin
                lane[k][j] = (dir_reg == DIR_COLS) ? store_reg[j][k] : store_reg[k][j];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < PATCH_DIM; k++)
        begin
            l1_next[k]  = half_sum(lane[k][0], lane[k][1]);
            mid_next[k] = half_sum(lane[k][1], lane[k][2]);
            r2_next[k]  = half_sum(lane[k][2], lane[k][3]);
            l2_next[k]  = half_sum(l1_reg[k], mid_reg[k]);
            r1_next[k]  = half_sum(mid_reg[k], r2_reg[k]);
            c_next[k]   = half_sum(l2_reg[k], r1_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_ROWS;
        end
        else if (cmd.load_dir)
        begin
            dir_reg <= mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
        begin
            for (int j = 0; j < PATCH_DIM; j++)
            begin
                store_reg[cmd.store_row][j] <= coef[j];
            end
        end
        for (int k = 0; k < PATCH_DIM; k++)
        begin
            if (cmd.step1)
            begin
                l1_reg[k]  <= l1_next[k];
                mid_reg[k] <= mid_next[k];
                r2_reg[k]  <= r2_next[k];
            end
            if (cmd.step2)
            begin
                l2_reg[k] <= l2_next[k];
                r1_reg[k] <= r1_next[k];
            end
            if (cmd.step3)
            begin
                c_reg[k] <= c_next[k];
            end
        end
    end

    // halves per lane, end points straight from the store
    always_comb
    begin
        for (int k = 0; k < PATCH_DIM; k++)
        begin
            lft[k][0] = lane[k][0];
            lft[k][1] = l1_reg[k];
            lft[k][2] = l2_reg[k];
            lft[k][3] = c_reg[k];
            rgt[k][0] = c_reg[k];
            rgt[k][1] = r1_reg[k];
            rgt[k][2] = r2_reg[k];
            rgt[k][3] = lane[k][3];
        end
    end

    always_comb
    begin
        for (int j = 0; j < PATCH_DIM; j++)
        begin
            if (dir_reg == DIR_COLS)
            begin
                left[j]  = lft[j][cmd.emit_row];
                right[j] = rgt[j][cmd.emit_row];
            end
            else
            begin
                left[j]  = lft[cmd.emit_row][j];
                right[j] = rgt[cmd.emit_row][j];
            end
        end
    end

endmodule

>>> hw/rtl/bbhs_ctrl.sv
// controller: row counting, halving sequence and result emission
module bbhs_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      result_strobe,
    output logic                      last_row,
    output logic [bbhs_pkg::ROW_BITS-1:0] row_index,
    output bbhs_pkg::bbhs_cmd_t       cmd
);
    import bbhs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_CALC3,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                busy_reg;
    logic [ROW_BITS-1:0] rows_reg;
    logic [ROW_BITS-1:0] emit_row_reg;
    logic                accept;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            busy_reg     <= 1'b0;
            rows_reg     <= FIRST_ROW;
            emit_row_reg <= FIRST_ROW;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rows_reg <= rows_reg + 1'b1;
                        if (rows_reg == LAST_ROW)
                        begin
                            state_reg <= ST_CALC1;
                            busy_reg  <= 1'b1;
                        end
                    end
                end
                ST_CALC1:
                begin
                    state_reg <= ST_CALC2;
                end
                ST_CALC2:
                begin
                    state_reg <= ST_CALC3;
                end
                ST_CALC3:
                begin
                    state_reg    <= ST_EMIT;
                    emit_row_reg <= FIRST_ROW;
                end
                ST_EMIT:
                begin
                    emit_row_reg <= emit_row_reg + 1'b1;
                    if (emit_row_reg == LAST_ROW)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.store_en  = accept;
        cmd.store_row = rows_reg;
        cmd.load_dir  = accept && (rows_reg == FIRST_ROW);
        cmd.step1     = (state_reg == ST_CALC1);
        cmd.step2     = (state_reg == ST_CALC2);
        cmd.step3     = (state_reg == ST_CALC3);
        cmd.emit_row  = emit_row_reg;
    end

    assign busy          = busy_reg;
    assign result_strobe = (state_reg == ST_EMIT);
    assign row_index     = emit_row_reg;
    assign last_row      = (state_reg == ST_EMIT) && (emit_row_reg == LAST_ROW);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> busy_reg)
        else $error("result strobe outside busy window");

    a_fourth_row_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg && rows_reg == LAST_ROW) |=> (busy_reg && state_reg == ST_CALC1))
        else $error("fourth row did not start the halving");

    a_count_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rows_reg == FIRST_ROW))
        else $error("row count not wrapped while busy");

    a_emit_four: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_row_reg != LAST_ROW) |=> (state_reg == ST_EMIT))
        else $error("emission cut short");

endmodule

>>> hw/rtl/bicubic_bezier_half_subdivide.sv
// top level: bicubic bezier patch halving at one half, controller plus datapath
// sequence: the fourth row of a patch is taken, then the three averaging levels run in
//   CALC1, CALC2 and CALC3, then the four result rows 0 to 3 are shown in order
// intake: rows one to three are taken whenever start is high and busy is low; the fourth
//   sets busy, which stays high through the three-level averaging chain and the result rows
// reset: rst_n asynchronous, clears row count, direction and sequencer; store undefined
// results are shown for one cycle each under result_strobe; the receiver cannot stall
module bicubic_bezier_half_subdivide #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] coef_0,
    input  logic signed [VALUE_WIDTH-1:0] coef_1,
    input  logic signed [VALUE_WIDTH-1:0] coef_2,
    input  logic signed [VALUE_WIDTH-1:0] coef_3,
    input  logic                          mode,
    output logic                          result_strobe,
    output logic [1:0]                    row_index,
    output logic signed [VALUE_WIDTH-1:0] left_0,
    output logic signed [VALUE_WIDTH-1:0] left_1,
    output logic signed [VALUE_WIDTH-1:0] left_2,
    output logic signed [VALUE_WIDTH-1:0] left_3,
    output logic signed [VALUE_WIDTH-1:0] right_0,
    output logic signed [VALUE_WIDTH-1:0] right_1,
    output logic signed [VALUE_WIDTH-1:0] right_2,
    output logic signed [VALUE_WIDTH-1:0] right_3,
    output logic                          last_row
);
    import bbhs_pkg::*;

    bbhs_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] coef  [PATCH_DIM];
    logic [VALUE_WIDTH-1:0] left  [PATCH_DIM];
    logic [VALUE_WIDTH-1:0] right [PATCH_DIM];

    // gather the row request into one array for the lanes
    assign coef[0] = coef_0;
    assign coef[1] = coef_1;
    assign coef[2] = coef_2;
    assign coef[3] = coef_3;

    // sequencer: counts rows, runs the three averaging levels, then walks the result rows
    bbhs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .result_strobe (result_strobe),
        .last_row      (last_row),
        .row_index     (row_index),
        .cmd           (cmd)
    );

    // store and four halving lanes, one per row or per column depending on direction
    bbhs_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .coef  (coef),
        .mode  (mode),
        .left  (left),
        .right (right)
    );

    assign left_0  = left[0];
    assign left_1  = left[1];
    assign left_2  = left[2];
    assign left_3  = left[3];
    assign right_0 = right[0];
    assign right_1 = right[1];
    assign right_2 = right[2];
    assign right_3 = right[3];

endmodule

>>> sim/patch_split_checker.sv
// checker for the patch halving block: predicts each split and compares the result rows
`timescale 1ns / 100ps

module patch_split_checker #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] coef_0,
    input  logic [VALUE_WIDTH-1:0] coef_1,
    input  logic [VALUE_WIDTH-1:0] coef_2,
    input  logic [VALUE_WIDTH-1:0] coef_3,
    input  logic                   mode,
    input  logic                   result_strobe,
    input  logic [1:0]             row_index,
    input  logic [VALUE_WIDTH-1:0] left_0,
    input  logic [VALUE_WIDTH-1:0] left_1,
    input  logic [VALUE_WIDTH-1:0] left_2,
    input  logic [VALUE_WIDTH-1:0] left_3,
    input  logic [VALUE_WIDTH-1:0] right_0,
    input  logic [VALUE_WIDTH-1:0] right_1,
    input  logic [VALUE_WIDTH-1:0] right_2,
    input  logic [VALUE_WIDTH-1:0] right_3,
    input  logic                   last_row,
    output int                     mismatches,
    output int                     outstanding
);
    import bbhs_pkg::*;

    typedef logic [PATCH_DIM-1:0][VALUE_WIDTH-1:0] quad_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        quad_t               lft;
        quad_t               rgt;
        logic                last;
    } half_row_t;

    // predictor state
    quad_t               patch_rows [PATCH_DIM];
    logic [ROW_BITS-1:0] rows_taken;
    logic                split_dir;
    half_row_t           pending_halves [$];
    int                  mismatch_tally;

    // shared per-edge working variables
    quad_t     line, lo, hi, got_lft, got_rgt;
    quad_t     lft_half [PATCH_DIM];
    quad_t     rgt_half [PATCH_DIM];
    half_row_t want;

    // floor of the mean, from the exact one-bit-wider sum
    function automatic logic [VALUE_WIDTH-1:0] midpoint(input logic [VALUE_WIDTH-1:0] a,
                                                        input logic [VALUE_WIDTH-1:0] b);
        logic signed [VALUE_WIDTH:0] total;
        total = $signed(a) + $signed(b);
        return total[VALUE_WIDTH:1];
    endfunction

    // de casteljau at one half over four control values
    function automatic void split_line(input quad_t p, output quad_t l, output quad_t r);
        logic [VALUE_WIDTH-1:0] mid, l1, r2, l2, r1, c;
        mid = midpoint(p[1], p[2]);
        l1  = midpoint(p[0], p[1]);
        r2  = midpoint(p[2], p[3]);
        l2  = midpoint(l1, mid);
        r1  = midpoint(mid, r2);
        c   = midpoint(l2, r1);
        l   = {c, l2, l1, p[0]};
        r   = {p[3], r2, r1, c};
    endfunction

    task automatic check_field(input string what, input logic [1:0] row,
                               input logic [VALUE_WIDTH-1:0] exp_val,
                               input logic [VALUE_WIDTH-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: row %0d %s mismatch, expected %h actual %h",
                     $time, row, what, exp_val, act_val);
            mismatch_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_taken = FIRST_ROW;
            split_dir  = DIR_ROWS;
            pending_halves.delete();
            mismatch_tally = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (pending_halves.size() == 0)
                begin
                    $display("%0t: unexpected result row %0d", $time, row_index);
                    mismatch_tally++;
                end
                else
                begin
                    want    = pending_halves.pop_front();
                    got_lft = {left_3, left_2, left_1, left_0};
                    got_rgt = {right_3, right_2, right_1, right_0};
                    check_field("row_index", want.row, want.row, row_index);
                    check_field("last_row", want.row, want.last, last_row);
                    for (int j = 0; j < PATCH_DIM; j++)
                    begin
                        check_field($sformatf("left_%0d", j), want.row,
                                    want.lft[j], got_lft[j]);
                        check_field($sformatf("right_%0d", j), want.row,
                                    want.rgt[j], got_rgt[j]);
                    end
                end
            end

            if (start && !busy)
            begin
                if (rows_taken == FIRST_ROW)
                    split_dir = mode;
                patch_rows[rows_taken] = {coef_3, coef_2, coef_1, coef_0};
                if (rows_taken == LAST_ROW)
                begin
                    for (int k = 0; k < PATCH_DIM; k++)
                    begin
                        if (split_dir == DIR_ROWS)
                        begin
                            split_line(patch_rows[k], lo, hi);
                            lft_half[k] = lo;
                            rgt_half[k] = hi;
                        end
                        else
                        begin
                            for (int j = 0; j < PATCH_DIM; j++)
                                line[j] = patch_rows[j][k];
                            split_line(line, lo, hi);
                            for (int j = 0; j < PATCH_DIM; j++)
                            begin
                                lft_half[j][k] = lo[j];
                                rgt_half[j][k] = hi[j];
                            end
                        end
                    end
                    for (int r = 0; r < PATCH_DIM; r++)
                        pending_halves.push_back('{row: ROW_BITS'(r), lft: lft_half[r],
                                                   rgt: rgt_half[r],
                                                   last: (ROW_BITS'(r) == LAST_ROW)});
                    rows_taken = FIRST_ROW;
                end
                else
                    rows_taken++;
            end
        end
        mismatches  <= mismatch_tally;
        outstanding <= pending_halves.size();
    end

endmodule

>>> sim/testbench.sv
// top of the testbench for the patch halving block: stimulus, timeout and verdict
`timescale 1ns / 100ps

module testbench;

    import bbhs_pkg::*;

    localparam int unsigned VALUE_WIDTH   = 32;
    localparam int          RANDOM_PATCHES = 74;   // 296 rows after the 24 directed ones
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 12;    // extra wait for stray result rows once none are outstanding

    localparam logic [VALUE_WIDTH-1:0] MAX_COEF = 32'h7fff_ffff;
    localparam logic [VALUE_WIDTH-1:0] MIN_COEF = 32'h8000_0000;

    typedef logic [PATCH_DIM-1:0][PATCH_DIM-1:0][VALUE_WIDTH-1:0] patch_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] coef_0;
    logic signed [VALUE_WIDTH-1:0] coef_1;
    logic signed [VALUE_WIDTH-1:0] coef_2;
    logic signed [VALUE_WIDTH-1:0] coef_3;
    logic                          mode;
    logic                          result_strobe;
    logic [1:0]                    row_index;
    logic signed [VALUE_WIDTH-1:0] left_0;
    logic signed [VALUE_WIDTH-1:0] left_1;
    logic signed [VALUE_WIDTH-1:0] left_2;
    logic signed [VALUE_WIDTH-1:0] left_3;
    logic signed [VALUE_WIDTH-1:0] right_0;
    logic signed [VALUE_WIDTH-1:0] right_1;
    logic signed [VALUE_WIDTH-1:0] right_2;
    logic signed [VALUE_WIDTH-1:0] right_3;
    logic                          last_row;
    int                            mismatches;
    int                            outstanding;
    int                            cycle_count;

    patch_t     patch;
    logic [3:0] row_modes;

    bicubic_bezier_half_subdivide #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (.*);

    // predicts the halves and compares every result row
    patch_split_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_checker (.*);

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: a lost result row or a stuck busy ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // idle cycles before a request: mostly none or a few, now and then a long pause
    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // control values biased towards the extremes and towards small numbers near zero,
    // where the rounding towards minus infinity shows
    function automatic logic [VALUE_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return MAX_COEF;
            1:       return MIN_COEF;
            2, 3:    return $urandom_range(0, 15) - 32'd8;
            4:       return $urandom_range(0, 1) ? MAX_COEF - $urandom_range(0, 3)
                                                 : MIN_COEF + $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // one row request; start is left high so back-to-back requests need no gap
    task automatic send_row(input logic [PATCH_DIM-1:0][VALUE_WIDTH-1:0] row_vals,
                            input logic row_mode, input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        coef_0 <= row_vals[0];
        coef_1 <= row_vals[1];
        coef_2 <= row_vals[2];
        coef_3 <= row_vals[3];
        mode   <= row_mode;
        @(posedge clk);
        // busy read here is the value the edge just used
        while (busy)
            @(posedge clk);
    endtask

    // four rows make one patch; only the first row's mode matters to the block
    task automatic send_patch(input patch_t rows, input logic [3:0] modes, input bit calm);
        for (int r = 0; r < PATCH_DIM; r++)
            send_row(rows[r], modes[r], calm);
    endtask

    initial
    begin
        cycle_count = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        coef_0 = '0;
        coef_1 = '0;
        coef_2 = '0;
        coef_3 = '0;
        mode   = DIR_ROWS;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all at the positive limit, split along rows
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = MAX_COEF;
        send_patch(patch, {4{DIR_ROWS}}, 1'b1);

        // all at the negative limit, split along columns
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = MIN_COEF;
        send_patch(patch, {4{DIR_COLS}}, 1'b0);

        // chequerboard of both limits: largest steps between neighbours either way; mode flips after the
        // first row must be ignored
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = ((r + c) % 2) ? MIN_COEF : MAX_COEF;
        send_patch(patch, {DIR_COLS, DIR_COLS, DIR_COLS, DIR_ROWS}, 1'b1);
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = ((r + c) % 2) ? MAX_COEF : MIN_COEF;
        send_patch(patch, {DIR_ROWS, DIR_ROWS, DIR_ROWS, DIR_COLS}, 1'b0);

        // minus one, zero and one mixed: odd sums round down, also below zero
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = ((r + 2 * c) % 3) - 1;
        send_patch(patch, {4{DIR_ROWS}}, 1'b1);

        // odd values of alternating sign along columns
        for (int r = 0; r < PATCH_DIM; r++)
            for (int c = 0; c < PATCH_DIM; c++)
                patch[r][c] = ((r + c) % 2) ? -(2 * (4 * r + c) + 1) : 2 * (4 * r + c) + 1;
        send_patch(patch, {4{DIR_COLS}}, 1'b0);

        // random patches, a quarter of them sent without any idling
        for (int p = 0; p < RANDOM_PATCHES; p++)
        begin
            for (int r = 0; r < PATCH_DIM; r++)
                for (int c = 0; c < PATCH_DIM; c++)
                    patch[r][c] = pick_coef();
            row_modes = 4'($urandom_range(0, 15));
            send_patch(patch, row_modes, $urandom_range(0, 3) == 0);
        end
        start <= 1'b0;

        // let the last patch drain, then allow a few more cycles for stray rows
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/bbhs_pkg.sv
hw/rtl/bbhs_datapath.sv
hw/rtl/bbhs_ctrl.sv
hw/rtl/bicubic_bezier_half_subdivide.sv
sim/patch_split_checker.sv
sim/testbench.sv
